[sv/selectable_fir_position_smoother_defines.svh]
// Assertion macros shared by the position smoother RTL
`ifndef SELECTABLE_FIR_POSITION_SMOOTHER_DEFINES_SVH
`define SELECTABLE_FIR_POSITION_SMOOTHER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SFPS_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfps: implication check failed");

// next-cycle implication, checked outside reset
`define SFPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfps: next-cycle check failed");

`endif

[sv/sfps_pkg.sv]
// Shared types, widths and coefficient table of the position smoother
package sfps_pkg;

    localparam int TAPS     = 8;
    localparam int NUM_SETS = 5;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 9;
    localparam int PROD_W   = 26;
    localparam int LEVEL_W  = 3;
    localparam int TAP_W    = $clog2(TAPS);
    localparam int SET_W    = $clog2(NUM_SETS);
    localparam int POS_W    = 17;
    localparam int FRAC_W   = 8;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic [COEF_W-1:0]          t_coef;

    // per-cell strobes: advance the sample line, register the product
    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    localparam t_coef COEF [NUM_SETS][TAPS] = '{
        '{9'd256, 9'd0,  9'd0,  9'd0,  9'd0,  9'd0,  9'd0,  9'd0},
        '{9'd135, 9'd69, 9'd35, 9'd17, 9'd0,  9'd0,  9'd0,  9'd0},
        '{9'd90,  9'd89, 9'd44, 9'd22, 9'd11, 9'd0,  9'd0,  9'd0},
        '{9'd69,  9'd57, 9'd46, 9'd36, 9'd28, 9'd20, 9'd0,  9'd0},
        '{9'd32,  9'd32, 9'd32, 9'd32, 9'd32, 9'd32, 9'd32, 9'd32}
    };

    // levels above the last set select the last set
    function automatic t_coef tap_coef(input logic [LEVEL_W-1:0] level,
                                       input logic [TAP_W-1:0] tap);
        logic [SET_W-1:0] set;
        if (level > LEVEL_W'(NUM_SETS - 1)) begin
            set = SET_W'(NUM_SETS - 1);
        end else begin
            set = level[SET_W-1:0];
        end
        return COEF[set][tap];
    endfunction

endpackage

[sv/sfps_cell.sv]
// One tap cell: holds a sample, passes it on, forms its weighted product
module sfps_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfps_pkg::t_cell_ctl i_ctl,
    input  sfps_pkg::t_sample  i_sample,
    input  sfps_pkg::t_coef    i_coef,
    output sfps_pkg::t_sample  o_sample,
    output sfps_pkg::t_prod    o_product
);

    sfps_pkg::t_sample r_sample;
    sfps_pkg::t_prod   r_product;
    sfps_pkg::t_prod   n_product;

    assign n_product = sfps_pkg::PROD_W'(r_sample * $signed({1'b0, i_coef}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_ctl.shift) begin
            r_sample <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_product <= n_product;
        end
    end

    assign o_sample  = r_sample;
    assign o_product = r_product;

endmodule

[sv/sfps_tree.sv]
// Registered sum of the tap products
module sfps_tree (
    input  logic              i_clk,
    input  logic              i_load,
    input  sfps_pkg::t_prod   i_products [sfps_pkg::TAPS],
    output sfps_pkg::t_prod   o_acc
);

    sfps_pkg::t_prod r_acc;
    sfps_pkg::t_prod n_acc;

    always_comb begin
        n_acc = '0;
        for (int k = 0; k < sfps_pkg::TAPS; k++) begin
            n_acc = n_acc + i_products[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

[sv/selectable_fir_position_smoother.sv]
// Top level of the selectable FIR position smoother
//
// Input channel: i_sample / i_pressed under i_valid / o_ready. Every transfer
// pushes the sample into an eight-cell shift line (newest in cell 0), whether
// or not a press is flagged.
// Output channel: o_position / o_valid_res under o_valid / i_ready, one result
// per input. o_position is a signed numerator over 65535; with no press it is
// 0 and o_valid_res is 0.
// Configuration: i_cfg_we writes i_cfg_wdata into the smoothing level; write
// only while no item is in flight. Levels 5..7 act as 4.
// Path from input transfer to o_valid: sample register, product register, sum
// register, output register. Throughput: one item per cycle while i_ready
// stays high, set by the registered tap cells and the registered adder tree.
// Reset (synchronous, i_rst_n low): the sample line clears to zero, the level
// to 0 and all stage valids drop.
// Stall: when i_ready is low the result holds; the stages behind it keep
// filling, and o_ready falls only once every stage is occupied.
`include "selectable_fir_position_smoother_defines.svh"

module selectable_fir_position_smoother (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfps_pkg::LEVEL_W-1:0]   i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [sfps_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                           i_pressed,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [sfps_pkg::POS_W-1:0] o_position,
    output logic                           o_valid_res
);

    logic [sfps_pkg::LEVEL_W-1:0] r_level;
    logic r_v0, r_v1, r_v2, r_ov;
    logic r_p0, r_p1, r_p2;
    logic signed [sfps_pkg::POS_W-1:0] r_position;
    logic r_valid_res;

    logic en0, en1, en2, en3, w_accept;
    sfps_pkg::t_cell_ctl w_ctl;
    sfps_pkg::t_sample   w_samples [sfps_pkg::TAPS];
    sfps_pkg::t_prod     w_products [sfps_pkg::TAPS];
    sfps_pkg::t_prod     w_acc;
    sfps_pkg::t_prod     w_shr;
    logic                w_fix;
    logic [sfps_pkg::SAMPLE_W-1:0] w_quot;
    logic signed [sfps_pkg::POS_W-1:0] n_position;

    // stage advances when it is empty or the next one advances
    assign en3      = !r_ov || i_ready;
    assign en2      = !r_v2 || en3;
    assign en1      = !r_v1 || en2;
    assign en0      = !r_v0 || en1;
    assign o_ready  = en0;
    assign w_accept = i_valid && en0;

    assign w_ctl.shift = w_accept;
    assign w_ctl.load  = en1 && r_v0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_cfg_we) begin
            r_level <= i_cfg_wdata;
        end
    end

    genvar k;
    generate
        for (k = 0; k < sfps_pkg::TAPS; k++) begin : g_cell
            if (k == 0) begin : g_head
                sfps_cell u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctl     (w_ctl),
                    .i_sample  (i_sample),
                    .i_coef    (sfps_pkg::tap_coef(r_level, sfps_pkg::TAP_W'(k))),
                    .o_sample  (w_samples[k]),
                    .o_product (w_products[k])
                );
            end else begin : g_body
                sfps_cell u_cell (
                    .i_clk     (i_clk),
                    .i_rst_n   (i_rst_n),
                    .i_ctl     (w_ctl),
                    .i_sample  (w_samples[k-1]),
                    .i_coef    (sfps_pkg::tap_coef(r_level, sfps_pkg::TAP_W'(k))),
                    .o_sample  (w_samples[k]),
                    .o_product (w_products[k])
                );
            end
        end
    endgenerate

    sfps_tree u_tree (
        .i_clk      (i_clk),
        .i_load     (en2 && r_v1),
        .i_products (w_products),
        .o_acc      (w_acc)
    );

    // divide by 256 toward zero: bump the floor up for inexact negatives
    assign w_shr  = w_acc >>> sfps_pkg::FRAC_W;
    assign w_fix  = w_acc[sfps_pkg::PROD_W-1] && (w_acc[sfps_pkg::FRAC_W-1:0] != '0);
    assign w_quot = w_shr[sfps_pkg::SAMPLE_W-1:0] + sfps_pkg::SAMPLE_W'(w_fix);
    // 2q+1 spans -65535..65535, so no clamp is reachable
    assign n_position = r_p2 ? $signed({w_quot, 1'b1}) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en0) begin
                r_v0 <= i_valid;
            end
            if (en1) begin
                r_v1 <= r_v0;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_ov <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p0 <= i_pressed;
        end
        if (en1 && r_v0) begin
            r_p1 <= r_p0;
        end
        if (en2 && r_v1) begin
            r_p2 <= r_p1;
        end
        if (en3 && r_v2) begin
            r_position  <= n_position;
            r_valid_res <= r_p2;
        end
    end

    assign o_valid     = r_ov;
    assign o_position  = r_position;
    assign o_valid_res = r_valid_res;

    `SFPS_ASSERT_IMPLY(a_nopress_zero, o_valid && !o_valid_res, o_position == '0)
    `SFPS_ASSERT_IMPLY(a_press_odd, o_valid && o_valid_res, o_position[0] == 1'b1)
    `SFPS_ASSERT_NEXT(a_head_loaded, i_valid && o_ready, w_samples[0] == $past(i_sample))
    `SFPS_ASSERT_NEXT(a_stage_hold, r_v0 && !en1, r_v0 && $stable(w_samples[0]))

endmodule

[bench/selectable_fir_position_smoother_tb.sv]
// Self-checking bench for the selectable FIR position smoother: predicts every result
`timescale 1ns / 1ps

typedef struct packed {
    logic signed [sfps_pkg::POS_W-1:0] position;
    logic                              valid_res;
} t_smoothed_pos;

class position_scoreboard;
    localparam int RING = 8;
    localparam int POS_MAX = 65535;

    int coef_by_level [5][8] = '{
        '{256, 0,  0,  0,  0,  0,  0,  0},
        '{135, 69, 35, 17, 0,  0,  0,  0},
        '{90,  89, 44, 22, 11, 0,  0,  0},
        '{69,  57, 46, 36, 28, 20, 0,  0},
        '{32,  32, 32, 32, 32, 32, 32, 32}
    };

    sfps_pkg::t_sample            ring [RING];
    int unsigned                  newest;
    logic [sfps_pkg::LEVEL_W-1:0] level;
    t_smoothed_pos                expected_pos [$];
    int                           errors;

    function new();
        foreach (ring[i]) ring[i] = '0;
        newest = 0;
        level  = '0;
        errors = 0;
    endfunction

    function void set_level(input logic [sfps_pkg::LEVEL_W-1:0] value);
        level = value;
    endfunction

    function int pending();
        return expected_pos.size();
    endfunction

    // push the sample, then filter the newest taps if pressed
    function void note_input(input sfps_pkg::t_sample sample, input logic pressed);
        t_smoothed_pos res;
        int set_idx;
        int acc;
        int quot;
        int num;
        newest = (newest + 1) % RING;
        ring[newest] = sample;
        if (!pressed) begin
            res.position  = '0;
            res.valid_res = 1'b0;
        end else begin
            set_idx = (level > 4) ? 4 : int'(level);
            acc = 0;
            for (int tap = 0; tap < RING; tap++) begin
                acc += int'(ring[(newest + RING - tap) % RING]) * coef_by_level[set_idx][tap];
            end
            // integer division truncates toward zero
            quot = acc / 256;
            num  = quot * 2 + 1;
            if (num > POS_MAX) num = POS_MAX;
            if (num < -POS_MAX) num = -POS_MAX;
            res.position  = sfps_pkg::POS_W'(num);
            res.valid_res = 1'b1;
        end
        expected_pos.push_back(res);
    endfunction

    function void check_result(input logic signed [sfps_pkg::POS_W-1:0] position,
                               input logic valid_res);
        t_smoothed_pos exp_res;
        if (expected_pos.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: position %0d valid %0b", position, valid_res);
        end else begin
            exp_res = expected_pos.pop_front();
            if (exp_res.position !== position || exp_res.valid_res !== valid_res) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: expected position %0d valid %0b,",
                              " got position %0d valid %0b"},
                             exp_res.position, exp_res.valid_res, position, valid_res);
            end
        end
    endfunction
endclass

module selectable_fir_position_smoother_tb;
    localparam int IDLE_LIMIT = 4000;
    localparam int CHUNKS     = 20;
    localparam int CHUNK_LEN  = 35;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_cfg_we = 1'b0;
    logic [sfps_pkg::LEVEL_W-1:0]         i_cfg_wdata = '0;
    logic                                 i_valid = 1'b0;
    logic                                 o_ready;
    logic signed [sfps_pkg::SAMPLE_W-1:0] i_sample = '0;
    logic                                 i_pressed = 1'b0;
    logic                                 o_valid;
    logic                                 i_ready = 1'b1;
    logic signed [sfps_pkg::POS_W-1:0]    o_position;
    logic                                 o_valid_res;

    position_scoreboard sb = new();
    int gap_pct = 0;
    int stall_pct = 0;
    int idle_cycles = 0;

    selectable_fir_position_smoother i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_sample    (i_sample),
        .i_pressed   (i_pressed),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_position  (o_position),
        .o_valid_res (o_valid_res)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side: check transfers, stall at random, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_result(o_position, o_valid_res);
            if ((o_valid && i_ready) || (i_valid && o_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            i_ready <= ($urandom_range(99) < stall_pct) ? 1'b0 : 1'b1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("selectable_fir_position_smoother regression: fail");
                $finish;
            end
        end
    end

    task automatic push_sample(input sfps_pkg::t_sample sample, input logic pressed);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_sample  <= sample;
        i_pressed <= pressed;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(sample, pressed);
    endtask

    // hold off until every result is out, plus the pipeline depth
    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_level(input logic [sfps_pkg::LEVEL_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_level(value);
    endtask

    function automatic sfps_pkg::t_sample rand_sample();
        case ($urandom_range(7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return sfps_pkg::t_sample'(int'($urandom_range(15)) - 8);
            default: return sfps_pkg::t_sample'($urandom);
        endcase
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // eight equal taps on an empty ring: unwritten cells count as zero
        write_level(3'd4);
        repeat (4) push_sample(16'sh7fff, 1'b1);
        push_sample(16'sh8000, 1'b0);
        drain();
        // levels above four act as four
        write_level(3'd7);
        repeat (3) push_sample(16'sh8000, 1'b1);
        drain();
        write_level(3'd0);
        push_sample(16'sh7fff, 1'b1);
        push_sample(16'sh8000, 1'b1);
        push_sample(-16'sd1, 1'b1);
        push_sample(16'sd0, 1'b1);
        push_sample(16'sh7fff, 1'b0);
        // levels 1 to 3: a pressed -1 sample, then a pressed +1 sample
        for (int lv = 1; lv <= 3; lv++) begin
            drain();
            write_level(sfps_pkg::LEVEL_W'(lv));
            push_sample(-16'sd1, 1'b1);
            push_sample(16'sd1, 1'b1);
        end

        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            drain();
            case (chunk % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 80; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 80; end
                default: begin gap_pct = 8; stall_pct = 8; end
            endcase
            write_level(chunk < 8 ? sfps_pkg::LEVEL_W'(chunk)
                                  : sfps_pkg::LEVEL_W'($urandom_range(7)));
            for (int n = 0; n < CHUNK_LEN; n++)
                push_sample(rand_sample(), $urandom_range(3) != 0);
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("selectable_fir_position_smoother regression: pass");
        end else begin
            $display("selectable_fir_position_smoother regression: fail");
        end
        $finish;
    end
endmodule
